FILE: sv/krac_pkg.sv
// Shared types and constants of the key record format converter.
// Used by every module of the block; depends on nothing.
package krac_pkg;

   localparam logic [1:0] CSR_SRC_FORMAT    = 2'd0;
   localparam logic [1:0] CSR_DST_FORMAT    = 2'd1;
   localparam logic [1:0] CSR_NATIVE_FORMAT = 2'd2;

   localparam logic [1:0] FMT_RESET = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_NATIVE = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_TOO_SMALL = 3'd3;
   localparam logic [2:0] ST_OVERRUN   = 3'd4;
   localparam logic [2:0] ST_TRAILING  = 3'd5;

   localparam int NUM_WORDS = 5;

   typedef struct packed {
      logic       in_valid_byte;
      logic [7:0] in_data;
      logic       in_end;
   } krac_req_type;

   typedef struct packed {
      logic       out_has_byte;
      logic [7:0] out_data;
      logic       run_last;
      logic       status_valid;
      logic [2:0] status_code;
   } krac_rsp_type;

   typedef struct packed {
      logic [1:0] src_format;
      logic [1:0] dst_format;
      logic [1:0] native_format;
   } krac_cfg_type;

   // One decoded unit of work: optional byte with trailing zero pad,
   // optional rewritten header, optional final status.
   typedef struct packed {
      logic                            byte_en;
      logic [7:0]                      data;
      logic [2:0]                      pad;
      logic                            hdr_en;
      logic [1:0]                      fmt;
      logic [NUM_WORDS-1:0][63:0]      words;
      logic                            stat_en;
      logic [2:0]                      code;
   } krac_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } krac_qstat_type;

endpackage

FILE: sv/krac_front.sv
// Front end: parses the byte stream, assembles and checks headers, and
// issues work commands. Depends on krac_pkg.
module krac_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  krac_pkg::krac_req_type req_data,
   input  krac_pkg::krac_cfg_type cfg,
   input  logic                  q_full,
   output logic                  cmd_push,
   output krac_pkg::krac_cmd_type cmd_data
);
   import krac_pkg::*;

   typedef enum logic [1:0] {PH_HDR, PH_DATA, PH_SKIP, PH_DRAIN} phase_type;
   typedef enum logic [1:0] {F_IDLE, F_SUM, F_ADD, F_CHECK} fin_type;

   phase_type             phase_ff, phase_in;
   fin_type               fin_ff, fin_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [4:0][63:0]      words_ff, words_in;
   logic [63:0]           cl_ff, cl_in;
   logic [63:0]           skip_ff, skip_in;
   logic [2:0]            err_ff, err_in;
   logic [2:0]            real_lo_ff, real_lo_in;
   logic                  pend_end_ff, pend_end_in;
   logic [64:0]           sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [63:0]           real_ff, real_in;
   logic                  carry_ff, carry_in;

   logic                  accept, sw8, dw8, go_fin, big, too_small, ovf;
   logic [3:0]            idx;
   logic [2:0]            pos, mask;
   logic [63:0]           w, dec, hdr64, a;
   logic [65:0]           s66;
   logic [64:0]           tot;
   logic [5:0]            hdr_len;
   krac_cmd_type          cmd;

   function automatic logic [2:0] status_of(input logic [2:0] e, input phase_type p,
                                            input logic [5:0] c);
      logic [2:0] r;
      r = e;
      if (e == ST_OK) begin
         if (p == PH_HDR && c != 6'd0) r = ST_TRAILING;
         else if (p == PH_DATA || p == PH_SKIP) r = ST_OVERRUN;
      end
      return r;
   endfunction

   assign accept   = req_push && !req_full;
   assign req_full = (fin_ff != F_IDLE) || q_full;
   assign cmd_data = cmd;

   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      cnt_in      = cnt_ff;
      words_in    = words_ff;
      cl_in       = cl_ff;
      skip_in     = skip_ff;
      err_in      = err_ff;
      real_lo_in  = real_lo_ff;
      pend_end_in = pend_end_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      real_in     = real_ff;
      carry_in    = carry_ff;
      cmd         = '0;
      cmd_push    = 1'b0;
      go_fin      = 1'b0;
      sw8         = cfg.src_format[1];
      dw8         = cfg.dst_format[1];
      mask        = dw8 ? 3'd7 : 3'd3;
      idx         = sw8 ? {1'b0, cnt_ff[5:3]} : cnt_ff[5:2];
      pos         = sw8 ? cnt_ff[2:0] : {1'b0, cnt_ff[1:0]};
      hdr_len     = sw8 ? 6'd40 : 6'd20;
      hdr64       = sw8 ? 64'd40 : 64'd20;
      w           = '0;
      dec         = '0;
      s66         = '0;
      big         = 1'b0;
      too_small   = 1'b0;
      ovf         = 1'b0;
      a           = words_ff[0] - hdr64;
      tot         = '0;
      unique case (fin_ff)
         F_IDLE: begin
            if (accept) begin
               if (err_ff == ST_OK && cfg.src_format != cfg.native_format &&
                   cfg.dst_format != cfg.native_format) begin
                  err_in   = ST_NO_NATIVE;
                  phase_in = PH_DRAIN;
               end
               if (req_data.in_valid_byte && err_in == ST_OK) begin
                  if (cfg.src_format == cfg.dst_format) begin
                     cmd.byte_en = 1'b1;
                     cmd.data    = req_data.in_data;
                  end else begin
                     unique case (phase_ff)
                        PH_HDR: begin
                           if (idx < 4'd5) begin
                              w = (pos == 3'd0) ? 64'd0 : words_ff[idx[2:0]];
                              if (cfg.src_format[0]) w = {w[55:0], req_data.in_data};
                              else w = w | ({56'd0, req_data.in_data} << {pos, 3'b000});
                              words_in[idx[2:0]] = w;
                           end
                           cnt_in = cnt_ff + 6'd1;
                           if (cnt_in >= hdr_len) begin
                              cnt_in = 6'd0;
                              go_fin = 1'b1;
                           end
                        end
                        PH_DATA: begin
                           cmd.byte_en = 1'b1;
                           cmd.data    = req_data.in_data;
                           dec = (cl_ff != 64'd0) ? cl_ff - 64'd1 : cl_ff;
                           cl_in = dec;
                           if (dec == 64'd0) begin
                              cmd.pad  = (3'd0 - real_lo_ff) & mask;
                              phase_in = (skip_ff != 64'd0) ? PH_SKIP : PH_HDR;
                           end
                        end
                        PH_SKIP: begin
                           dec = (skip_ff != 64'd0) ? skip_ff - 64'd1 : skip_ff;
                           skip_in = dec;
                           if (dec == 64'd0) phase_in = PH_HDR;
                        end
                        default: ;
                     endcase
                  end
               end
               if (go_fin) begin
                  fin_in      = F_SUM;
                  pend_end_in = req_data.in_end;
               end else if (req_data.in_end) begin
                  cmd.stat_en = 1'b1;
                  cmd.code    = status_of(err_in, phase_in, cnt_in);
                  phase_in    = PH_HDR;
                  cnt_in      = 6'd0;
                  cl_in       = 64'd0;
                  skip_in     = 64'd0;
                  err_in      = ST_OK;
               end
               cmd_push = cmd.byte_en || cmd.stat_en;
            end
         end
         F_SUM: begin
            sum_a_in = {1'b0, words_ff[1]} + {1'b0, words_ff[2]};
            sum_b_in = {1'b0, words_ff[3]} + {1'b0, words_ff[4]};
            fin_in   = F_ADD;
         end
         F_ADD: begin
            s66      = {1'b0, sum_a_ff} + {1'b0, sum_b_ff};
            real_in  = s66[63:0];
            carry_in = |s66[65:64];
            fin_in   = F_CHECK;
         end
         F_CHECK: begin
            if (!q_full) begin
               big = !dw8 && (|words_ff[0][63:32] || |words_ff[1][63:32] ||
                     |words_ff[2][63:32] || |words_ff[3][63:32] ||
                     |words_ff[4][63:32]);
               too_small = carry_ff || (words_ff[0] < hdr64) || (a < real_ff);
               tot = {1'b0, real_ff} + (dw8 ? 65'd40 : 65'd20) +
                     {62'd0, (3'd0 - real_ff[2:0]) & mask};
               ovf = dw8 ? tot[64] : |tot[64:32];
               if (big || (!too_small && ovf)) begin
                  err_in   = ST_OVERFLOW;
                  phase_in = PH_DRAIN;
               end else if (too_small) begin
                  err_in   = ST_TOO_SMALL;
                  phase_in = PH_DRAIN;
               end else begin
                  cmd.hdr_en   = 1'b1;
                  cmd.fmt      = cfg.dst_format;
                  cmd.words    = {words_ff[4:1], tot[63:0]};
                  cl_in        = real_ff;
                  skip_in      = a - real_ff;
                  real_lo_in   = real_ff[2:0];
                  phase_in     = (real_ff != 64'd0) ? PH_DATA :
                                 ((a != real_ff) ? PH_SKIP : PH_HDR);
               end
               if (pend_end_ff) begin
                  cmd.stat_en = 1'b1;
                  cmd.code    = status_of(err_in, phase_in, 6'd0);
                  phase_in    = PH_HDR;
                  cl_in       = 64'd0;
                  skip_in     = 64'd0;
                  err_in      = ST_OK;
               end
               cmd_push = cmd.hdr_en || cmd.stat_en;
               fin_in   = F_IDLE;
            end
         end
         default: fin_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         fin_ff   <= F_IDLE;
         cnt_ff   <= '0;
         words_ff <= '0;
         cl_ff    <= '0;
         skip_ff  <= '0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         cnt_ff   <= cnt_in;
         words_ff <= words_in;
         cl_ff    <= cl_in;
         skip_ff  <= skip_in;
         err_ff   <= err_in;
      end
      real_lo_ff  <= real_lo_in;
      pend_end_ff <= pend_end_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      real_ff     <= real_in;
      carry_ff    <= carry_in;
   end

endmodule

FILE: sv/krac_cmd_queue.sv
// Command queue between front and back end.
// Depends on krac_pkg.
module krac_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  krac_pkg::krac_cmd_type push_data,
   input  logic                   pop,
   output krac_pkg::krac_cmd_type head,
   output krac_pkg::krac_qstat_type stat
);
   import krac_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   krac_cmd_type   mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

FILE: sv/krac_back.sv
// Back end: expands commands into result words and buffers them in a
// two-entry output queue. Depends on krac_pkg.
module krac_back (
   input  logic                   clock,
   input  logic                   reset,
   input  krac_pkg::krac_cmd_type q_head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output krac_pkg::krac_rsp_type rsp_data
);
   import krac_pkg::*;

   krac_rsp_type  mem_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    cnt_ff, cnt_in;
   logic [5:0]    i_ff, i_in;
   logic [5:0]    c1, c2, c3, n, j;
   logic [2:0]    wsel, pos, sh, dwm1;
   logic          emit, do_pop;
   krac_rsp_type  r;

   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = mem_ff[rd_ff];
   assign do_pop    = rsp_pop && !rsp_empty;
   assign emit      = !q_empty && (cnt_ff != 2'd2);

   always_comb begin
      c1   = {5'd0, q_head.byte_en};
      c2   = c1 + (q_head.hdr_en ? (q_head.fmt[1] ? 6'd40 : 6'd20) : 6'd0);
      c3   = c2 + {3'd0, q_head.pad};
      n    = c3 + {5'd0, q_head.stat_en};
      j    = i_ff - c1;
      wsel = q_head.fmt[1] ? j[5:3] : j[4:2];
      pos  = q_head.fmt[1] ? j[2:0] : {1'b0, j[1:0]};
      dwm1 = q_head.fmt[1] ? 3'd7 : 3'd3;
      sh   = q_head.fmt[0] ? dwm1 - pos : pos;
      r    = '0;
      r.run_last = (i_ff == n - 6'd1);
      if (i_ff < c1) begin
         r.out_has_byte = 1'b1;
         r.out_data     = q_head.data;
      end else if (i_ff < c2) begin
         r.out_has_byte = 1'b1;
         if (wsel < 3'd5) r.out_data = q_head.words[wsel][{sh, 3'b000} +: 8];
      end else if (i_ff < c3) begin
         r.out_has_byte = 1'b1;
      end else begin
         r.status_valid = 1'b1;
         r.status_code  = q_head.code;
      end
      q_pop = emit && r.run_last;
      i_in  = i_ff;
      if (emit) i_in = r.run_last ? 6'd0 : i_ff + 6'd1;
      cnt_in = cnt_ff;
      if (emit && !do_pop) cnt_in = cnt_ff + 2'd1;
      else if (do_pop && !emit) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff   <= '0;
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         i_ff   <= i_in;
         cnt_ff <= cnt_in;
         if (emit)   wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
      end
      if (emit) mem_ff[wr_ff] <= r;
   end

endmodule

FILE: sv/key_record_arch_converter.sv
// Key record format converter, top level. Depends on krac_pkg and its modules.
// An input's first result word reaches the rsp_ ports via the command and output queues;
// a word that closes a header first passes the sum, add and check states. Throughput:
// one input word a cycle unless the command queue is full or a header is being summed or
// checked; the back end delivers one result word a cycle while its output queue has room.
// Reset is synchronous, active high; formats return to LE64, no clearing pass.
module key_record_arch_converter #(
   parameter int CMD_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  krac_pkg::krac_req_type req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output krac_pkg::krac_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [1:0]             csr_wdata
);
   import krac_pkg::*;

   krac_cfg_type   cfg_ff;
   krac_cmd_type   cmd, head;
   krac_qstat_type qstat;
   logic           cmd_push, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {FMT_RESET, FMT_RESET, FMT_RESET};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_FORMAT:    cfg_ff.src_format    <= csr_wdata;
            CSR_DST_FORMAT:    cfg_ff.dst_format    <= csr_wdata;
            CSR_NATIVE_FORMAT: cfg_ff.native_format <= csr_wdata;
            default: ;
         endcase
      end
   end

   krac_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (qstat.full),
      .cmd_push (cmd_push),
      .cmd_data (cmd)
   );

   krac_cmd_queue #(.DEPTH(CMD_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (q_pop),
      .head      (head),
      .stat      (qstat)
   );

   krac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (head),
      .q_empty   (qstat.empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status_valid) |-> (rsp_data.run_last && !rsp_data.out_has_byte))
      else $error("status word not last or carries a byte");
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_has_byte) |->
      (!rsp_data.status_valid && rsp_data.status_code == ST_OK))
      else $error("byte word carries status");
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status_valid) |-> (rsp_data.status_code <= ST_TRAILING))
      else $error("status code out of range");
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("command queue both full and empty");
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input stalled after reset");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the key record format converter.
// Needs krac_pkg and key_record_arch_converter; predicts every result word.
`timescale 1ns / 1ps

class krac_scoreboard;
   // predictor state
   logic [1:0]  src_fmt, dst_fmt, nat_fmt;
   logic [1:0]  phase;
   logic [5:0]  hdr_count;
   logic [63:0] len_word [5];
   logic [63:0] content_left, skip_left;
   logic [2:0]  err_code;
   krac_pkg::krac_rsp_type pending_words[$];
   krac_pkg::krac_rsp_type step_words[$];
   int          mismatches;

   function new();
      src_fmt = krac_pkg::FMT_RESET;
      dst_fmt = krac_pkg::FMT_RESET;
      nat_fmt = krac_pkg::FMT_RESET;
      for (int k = 0; k < 5; k++) len_word[k] = '0;
      clear_buffer();
      mismatches = 0;
   endfunction

   function void clear_buffer();
      phase = 2'd0;
      hdr_count = '0;
      content_left = '0;
      skip_left = '0;
      err_code = krac_pkg::ST_OK;
   endfunction

   function void set_reg(logic [1:0] idx, logic [1:0] val);
      case (idx)
         krac_pkg::CSR_SRC_FORMAT:    src_fmt = val;
         krac_pkg::CSR_DST_FORMAT:    dst_fmt = val;
         krac_pkg::CSR_NATIVE_FORMAT: nat_fmt = val;
         default: ;
      endcase
   endfunction

   function void emit(logic has, logic [7:0] d, logic sv, logic [2:0] sc);
      krac_pkg::krac_rsp_type w;
      w.out_has_byte = has;
      w.out_data = d;
      w.run_last = 1'b0;
      w.status_valid = sv;
      w.status_code = sc;
      step_words.push_back(w);
   endfunction

   function void emit_len(logic [63:0] v);
      int dw;
      int sh;
      dw = dst_fmt[1] ? 8 : 4;
      for (int i = 0; i < dw; i++) begin
         sh = dst_fmt[0] ? 8 * (dw - 1 - i) : 8 * i;
         emit(1'b1, v[sh +: 8], 1'b0, krac_pkg::ST_OK);
      end
   endfunction

   function void raise(logic [2:0] c);
      err_code = c;
      phase = 2'd3;
   endfunction

   function logic [63:0] content_sum(output logic carry);
      logic [64:0] s;
      s = '0;
      carry = 1'b0;
      for (int k = 1; k < 5; k++) begin
         s = {1'b0, s[63:0]} + {1'b0, len_word[k]};
         if (s[64]) carry = 1'b1;
      end
      return s[63:0];
   endfunction

   function void close_header();
      logic [63:0] hdr, nh, lim, real_sz, pad;
      logic carry;
      hdr = src_fmt[1] ? 64'd40 : 64'd20;
      nh = dst_fmt[1] ? 64'd40 : 64'd20;
      lim = dst_fmt[1] ? '1 : 64'hFFFF_FFFF;
      hdr_count = '0;
      for (int k = 0; k < 5; k++)
         if (len_word[k] > lim) begin
            raise(krac_pkg::ST_OVERFLOW);
            return;
         end
      real_sz = content_sum(carry);
      if (carry || len_word[0] < hdr || len_word[0] - hdr < real_sz) begin
         raise(krac_pkg::ST_TOO_SMALL);
         return;
      end
      pad = (64'd0 - real_sz) & (dst_fmt[1] ? 64'd7 : 64'd3);
      if (real_sz > lim - nh - pad) begin
         raise(krac_pkg::ST_OVERFLOW);
         return;
      end
      emit_len(nh + real_sz + pad);
      for (int k = 1; k < 5; k++) emit_len(len_word[k]);
      content_left = real_sz;
      skip_left = len_word[0] - hdr - real_sz;
      phase = (real_sz != 0) ? 2'd1 : (skip_left != 0 ? 2'd2 : 2'd0);
   endfunction

   function void header_byte(logic [7:0] b);
      int sw, idx, pos;
      sw = src_fmt[1] ? 8 : 4;
      idx = hdr_count / sw;
      pos = hdr_count % sw;
      if (idx < 5) begin
         if (pos == 0) len_word[idx] = '0;
         if (src_fmt[0]) len_word[idx] = {len_word[idx][55:0], b};
         else len_word[idx] = len_word[idx] | (64'(b) << (8 * pos));
      end
      hdr_count = hdr_count + 6'd1;
      if (hdr_count >= 5 * sw) close_header();
   endfunction

   function void content_byte(logic [7:0] b);
      logic [63:0] pad;
      logic carry;
      emit(1'b1, b, 1'b0, krac_pkg::ST_OK);
      if (content_left != 0) content_left--;
      if (content_left == 0) begin
         pad = (64'd0 - content_sum(carry)) & (dst_fmt[1] ? 64'd7 : 64'd3);
         for (int i = 0; i < pad; i++) emit(1'b1, 8'h00, 1'b0, krac_pkg::ST_OK);
         phase = (skip_left != 0) ? 2'd2 : 2'd0;
      end
   endfunction

   // note an accepted input word and queue the results it causes
   function void note_input(krac_pkg::krac_req_type w);
      logic [2:0] code;
      step_words.delete();
      if (err_code == krac_pkg::ST_OK && src_fmt != nat_fmt && dst_fmt != nat_fmt)
         raise(krac_pkg::ST_NO_NATIVE);
      if (w.in_valid_byte && err_code == krac_pkg::ST_OK) begin
         if (src_fmt == dst_fmt) emit(1'b1, w.in_data, 1'b0, krac_pkg::ST_OK);
         else if (phase == 2'd0) header_byte(w.in_data);
         else if (phase == 2'd1) content_byte(w.in_data);
         else if (phase == 2'd2) begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) phase = 2'd0;
         end
      end
      if (w.in_end) begin
         code = err_code;
         if (code == krac_pkg::ST_OK) begin
            if (phase == 2'd0 && hdr_count != 0) code = krac_pkg::ST_TRAILING;
            else if (phase == 2'd1 || phase == 2'd2) code = krac_pkg::ST_OVERRUN;
         end
         emit(1'b0, 8'h00, 1'b1, code);
         clear_buffer();
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1'b1;
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
   endfunction

   function void check_result(krac_pkg::krac_rsp_type got);
      krac_pkg::krac_rsp_type want;
      if (pending_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %h", got);
         return;
      end
      want = pending_words.pop_front();
      if (got.out_has_byte !== want.out_has_byte || got.out_data !== want.out_data ||
          got.run_last !== want.run_last || got.status_valid !== want.status_valid ||
          got.status_code !== want.status_code) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected has=%b data=%h last=%b sv=%b sc=%0d, got has=%b data=%h last=%b sv=%b sc=%0d",
                     want.out_has_byte, want.out_data, want.run_last, want.status_valid,
                     want.status_code, got.out_has_byte, got.out_data, got.run_last,
                     got.status_valid, got.status_code);
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   krac_pkg::krac_req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   krac_pkg::krac_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [1:0] csr_wdata = '0;

   krac_scoreboard conv_board;
   int  idle_pct_rx = 20;
   bit  rx_hold = 1'b0;
   int  quiet_cycles = 0;
   int  items_sent = 0;

   key_record_arch_converter u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: random pop, check each accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) conv_board.check_result(rsp_data);
         rsp_pop <= !rx_hold && ($urandom_range(99) >= idle_pct_rx);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // push stays high after the word is taken; the next caller drives or drops it
   task automatic send_word(logic vb, logic [7:0] d, logic e, int idle_pct);
      krac_pkg::krac_req_type w;
      w.in_valid_byte = vb;
      w.in_data = d;
      w.in_end = e;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      conv_board.note_input(w);
      items_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (conv_board.pending_words.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      conv_board.set_reg(idx, val);
   endtask

   task automatic set_formats(logic [1:0] s, logic [1:0] d, logic [1:0] n);
      drain();
      write_reg(krac_pkg::CSR_SRC_FORMAT, s);
      write_reg(krac_pkg::CSR_DST_FORMAT, d);
      write_reg(krac_pkg::CSR_NATIVE_FORMAT, n);
      csr_we <= 1'b0;
   endtask

   // one length word in the current source format
   task automatic send_len(logic [63:0] v, int idle_pct);
      int sw;
      int sh;
      sw = conv_board.src_fmt[1] ? 8 : 4;
      for (int i = 0; i < sw; i++) begin
         sh = conv_board.src_fmt[0] ? 8 * (sw - 1 - i) : 8 * i;
         send_word(1'b1, v[sh +: 8], 1'b0, idle_pct);
      end
   endtask

   // a record: header, content, source padding; mode picks a broken case
   task automatic send_record(int mode, int idle_pct);
      logic [63:0] w [5];
      int hdr, real_sz, skip;
      hdr = conv_board.src_fmt[1] ? 40 : 20;
      for (int k = 1; k < 5; k++) w[k] = 64'($urandom_range(3));
      real_sz = int'(w[1] + w[2] + w[3] + w[4]);
      skip = $urandom_range(5);
      w[0] = 64'(hdr + real_sz + skip);
      case (mode)
         1: w[0] = 64'(hdr - 1);
         2: w[2] = {32'h0000_0001, 32'h0};
         3: w[1] = '1;
         4: w[0] = {$urandom, $urandom};
         default: ;
      endcase
      for (int k = 0; k < 5; k++) send_len(w[k], idle_pct);
      for (int i = 0; i < real_sz + skip; i++)
         send_word(1'b1, 8'($urandom), 1'b0, idle_pct);
   endtask

   initial begin
      int fmt_s, fmt_d;
      conv_board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty buffer, pass-through, extremes, no-native, overflow and trailing errors
      send_word(1'b0, 8'h00, 1'b1, 0);
      send_word(1'b1, 8'h00, 1'b0, 0);
      send_word(1'b1, 8'hFF, 1'b1, 0);
      set_formats(2'd0, 2'd3, 2'd3);
      send_record(0, 0);
      send_word(1'b0, 8'h00, 1'b1, 0);
      set_formats(2'd3, 2'd0, 2'd3);
      send_record(2, 0);
      send_word(1'b0, 8'h00, 1'b1, 0);
      set_formats(2'd0, 2'd1, 2'd3);
      send_word(1'b1, 8'hA5, 1'b1, 0);
      set_formats(2'd1, 2'd2, 2'd1);
      send_len(64'd3, 0);
      send_word(1'b1, 8'h5A, 1'b1, 0);

      // random phases over randomly chosen format pairs
      for (int ph = 0; ph < 10; ph++) begin
         fmt_s = $urandom_range(3);
         fmt_d = $urandom_range(3);
         set_formats(fmt_s[1:0], fmt_d[1:0],
                     $urandom_range(9) == 0 ? 2'($urandom) :
                     ($urandom_range(1) ? fmt_s[1:0] : fmt_d[1:0]));
         if (ph == 5) begin
            rx_hold = 1'b1;
            fork
               begin repeat (400) @(posedge clock); rx_hold = 1'b0; end
            join_none
         end
         if (ph == 9) drain();
         idle_pct_rx = (ph == 3) ? 0 : 20;
         for (int r = 0; r < 1; r++) begin
            case ($urandom_range(9))
               0: send_record($urandom_range(4) + 1, (ph == 3) ? 0 : 20);
               1: send_word($urandom_range(1), 8'($urandom), 1'b0, 20);
               default: send_record(0, (ph == 3) ? 0 : 20);
            endcase
         end
         if ($urandom_range(4) == 0) send_word(1'b1, 8'($urandom), 1'b0, 20);
         send_word($urandom_range(1), 8'($urandom), 1'b1, 20);
      end

      drain();
      if (conv_board.mismatches == 0 && conv_board.pending_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
